// ===== src/tcgr_pkg.sv =====
`timescale 1ns / 1ps
package tcgr_pkg;

    localparam int GLYPH_ROWS      = 16;
    localparam int MAX_TEXT_COLS   = 256;
    localparam int MAX_TEXT_ROWS   = 64;
    localparam int MAX_LINE_STRIDE = 4096;
    localparam int MIN_LINE_STRIDE = 8;

    localparam int FONT_DEPTH  = 4096;
    localparam int FONT_AW     = $clog2(FONT_DEPTH);
    localparam int GROW_W      = $clog2(GLYPH_ROWS);
    localparam int COL_W       = 9;
    localparam int ROW_W       = 6;
    localparam int CFG_COLS_W  = 9;
    localparam int CFG_ROWS_W  = 7;
    localparam int STRIDE_W    = 13;
    localparam int PIX_W       = 22;
    localparam int COLOR_W     = 32;
    localparam int CODE_W      = 8;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [CODE_W-1:0] CHAR_NL = 8'h0A;
    localparam logic [CODE_W-1:0] CHAR_CR = 8'h0D;

    localparam logic REQ_CHAR    = 1'b0;
    localparam logic REQ_FONT    = 1'b1;
    localparam logic KIND_PIXELS = 1'b0;
    localparam logic KIND_SCROLL = 1'b1;

    typedef enum logic [2:0] {
        REG_FG,
        REG_BG,
        REG_COLS,
        REG_ROWS,
        REG_STRIDE
    } reg_index_t;

    typedef enum logic [1:0] {
        CMD_FONT,
        CMD_SCROLL,
        CMD_DRAW,
        CMD_SCROLL_DRAW
    } cmd_op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCROLL,
        ST_LEFT,
        ST_RIGHT
    } back_state_t;

    typedef struct packed {
        cmd_op_t               op;
        logic [ROW_W-1:0]      row;
        logic [COL_W-1:0]      col;
        logic [CODE_W-1:0]     code;
        logic [FONT_AW-1:0]    font_index;
        logic [7:0]            font_bits;
    } cmd_t;

    typedef struct packed {
        logic [COLOR_W-1:0]    fg;
        logic [COLOR_W-1:0]    bg;
        logic [COL_W-1:0]      cols;
        logic [ROW_W:0]        rows;
        logic [STRIDE_W-1:0]   stride;
    } cfg_t;

endpackage

// ===== src/tcgr_front.sv =====
`timescale 1ns / 1ps
module tcgr_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  tcgr_pkg::cfg_t               cfg,
    input  logic                         item_valid,
    output logic                         item_ready,
    input  logic                         req_type,
    input  logic [tcgr_pkg::CODE_W-1:0]  char_code,
    input  logic [tcgr_pkg::FONT_AW-1:0] font_index,
    input  logic [7:0]                   font_bits,
    input  logic                         queue_full,
    output logic                         push,
    output tcgr_pkg::cmd_t               push_cmd
);
    import tcgr_pkg::*;

    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [ROW_W-1:0] last_row, row_fit, draw_row;
    logic [COL_W-1:0] draw_col;
    logic             accept, at_last, wrap;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    always_comb
    begin
        item_ready = !queue_full;
        accept     = item_valid && item_ready;
        last_row   = ROW_W'(cfg.rows - 1'b1);
        // A cursor left below a shrunk screen is pulled up to the last row.
        row_fit    = ({1'b0, row_reg} >= cfg.rows) ? last_row : row_reg;
        at_last    = (row_fit == last_row);
        wrap       = (col_reg >= cfg.cols);
        draw_col   = wrap ? '0 : col_reg;
        draw_row   = (wrap && !at_last) ? ROW_W'(row_fit + 1'b1) : row_fit;

        push                = 1'b0;
        push_cmd.op         = CMD_FONT;
        push_cmd.row        = row_fit;
        push_cmd.col        = draw_col;
        push_cmd.code       = char_code;
        push_cmd.font_index = font_index;
        push_cmd.font_bits  = font_bits;
        col_next            = col_reg;
        row_next            = row_reg;

        if (accept)
        begin
            if (req_type == REQ_FONT)
            begin
                push = 1'b1;
            end
            else if (char_code == CHAR_NL)
            begin
                col_next = '0;
                if (at_last)
                begin
                    push        = 1'b1;
                    push_cmd.op = CMD_SCROLL;
                    row_next    = row_fit;
                end
                else
                begin
                    row_next = ROW_W'(row_fit + 1'b1);
                end
            end
            else if (char_code == CHAR_CR)
            begin
                col_next = '0;
                row_next = row_fit;
            end
            else
            begin
                push         = 1'b1;
                push_cmd.op  = (wrap && at_last) ? CMD_SCROLL_DRAW : CMD_DRAW;
                push_cmd.row = draw_row;
                row_next     = draw_row;
                col_next     = COL_W'(draw_col + 1'b1);
            end
        end
    end

endmodule

// ===== src/tcgr_queue.sv =====
`timescale 1ns / 1ps
module tcgr_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  tcgr_pkg::cmd_t push_cmd,
    output logic           full,
    input  logic           pop,
    output tcgr_pkg::cmd_t head,
    output logic           empty
);
    import tcgr_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t             slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_comb
    begin
        full        = (count_reg == CNT_W'(QUEUE_DEPTH));
        empty       = (count_reg == '0);
        head        = slot_reg[rd_ptr_reg];
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : PTR_W'(wr_ptr_reg + 1'b1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : PTR_W'(rd_ptr_reg + 1'b1);
        end
        if (push && !pop)
        begin
            count_next = CNT_W'(count_reg + 1'b1);
        end
        else if (pop && !push)
        begin
            count_next = CNT_W'(count_reg - 1'b1);
        end
    end

endmodule

// ===== src/tcgr_back.sv =====
`timescale 1ns / 1ps
module tcgr_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  tcgr_pkg::cfg_t               cfg,
    input  tcgr_pkg::cmd_t               head,
    input  logic                         empty,
    output logic                         pop,
    output logic                         result_valid,
    input  logic                         result_ready,
    output logic                         kind,
    output logic [tcgr_pkg::PIX_W-1:0]   pixel_index,
    output logic [tcgr_pkg::COLOR_W-1:0] color0,
    output logic [tcgr_pkg::COLOR_W-1:0] color1,
    output logic [tcgr_pkg::COLOR_W-1:0] color2,
    output logic [tcgr_pkg::COLOR_W-1:0] color3,
    output logic                         last
);
    import tcgr_pkg::*;

    logic [7:0]         font_mem [FONT_DEPTH];
    logic [7:0]         font_rd_reg;
    logic               mem_we, mem_re;
    logic [FONT_AW-1:0] rd_addr;

    back_state_t        state_reg, state_next;
    logic               draw_reg, draw_next;
    logic [CODE_W-1:0]  code_reg, code_next;
    logic [GROW_W-1:0]  grow_reg, grow_next;
    logic [PIX_W-1:0]   base_reg, base_next;

    logic               out_valid_reg, out_valid_next;
    logic               kind_reg, kind_next;
    logic [PIX_W-1:0]   pix_reg, pix_next;
    logic [COLOR_W-1:0] c0_reg, c0_next, c1_reg, c1_next;
    logic [COLOR_W-1:0] c2_reg, c2_next, c3_reg, c3_next;
    logic               last_reg, last_next;

    logic               load_ok, final_row;
    logic [3:0]         nib;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            font_mem[head.font_index] <= head.font_bits;
        end
        if (mem_re)
        begin
            font_rd_reg <= font_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        draw_reg <= draw_next;
        code_reg <= code_next;
        grow_reg <= grow_next;
        base_reg <= base_next;
        kind_reg <= kind_next;
        pix_reg  <= pix_next;
        c0_reg   <= c0_next;
        c1_reg   <= c1_next;
        c2_reg   <= c2_next;
        c3_reg   <= c3_next;
        last_reg <= last_next;
    end

    always_comb
    begin
        load_ok    = !out_valid_reg || result_ready;
        final_row  = (grow_reg == GROW_W'(GLYPH_ROWS - 1));
        nib        = (state_reg == ST_RIGHT) ? font_rd_reg[3:0] : font_rd_reg[7:4];
        state_next = state_reg;
        draw_next  = draw_reg;
        code_next  = code_reg;
        grow_next  = grow_reg;
        base_next  = base_reg;
        pop        = 1'b0;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        rd_addr    = FONT_AW'(32'(code_reg) * GLYPH_ROWS + 32'(grow_reg) + 32'd1);

        out_valid_next = out_valid_reg && !result_ready;
        kind_next      = kind_reg;
        pix_next       = pix_reg;
        c0_next        = c0_reg;
        c1_next        = c1_reg;
        c2_next        = c2_reg;
        c3_next        = c3_reg;
        last_next      = last_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (!empty)
                begin
                    pop       = 1'b1;
                    code_next = head.code;
                    grow_next = '0;
                    base_next = PIX_W'(32'(cfg.stride)
                                        * (32'(head.row) * GLYPH_ROWS)
                                        + 32'(head.col) * 32'd8);
                    rd_addr   = FONT_AW'(32'(head.code) * GLYPH_ROWS);
                    case (head.op)
                        CMD_FONT:
                        begin
                            mem_we = 1'b1;
                        end
                        CMD_SCROLL:
                        begin
                            draw_next  = 1'b0;
                            state_next = ST_SCROLL;
                        end
                        CMD_DRAW:
                        begin
                            mem_re     = 1'b1;
                            state_next = ST_LEFT;
                        end
                        CMD_SCROLL_DRAW:
                        begin
                            mem_re     = 1'b1;
                            draw_next  = 1'b1;
                            state_next = ST_SCROLL;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_SCROLL:
            begin
                if (load_ok)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = KIND_SCROLL;
                    pix_next       = '0;
                    c0_next        = cfg.bg;
                    c1_next        = '0;
                    c2_next        = '0;
                    c3_next        = '0;
                    last_next      = !draw_reg;
                    state_next     = draw_reg ? ST_LEFT : ST_IDLE;
                end
            end
            ST_LEFT, ST_RIGHT:
            begin
                if (load_ok)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = KIND_PIXELS;
                    c0_next        = nib[3] ? cfg.fg : cfg.bg;
                    c1_next        = nib[2] ? cfg.fg : cfg.bg;
                    c2_next        = nib[1] ? cfg.fg : cfg.bg;
                    c3_next        = nib[0] ? cfg.fg : cfg.bg;
                    if (state_reg == ST_LEFT)
                    begin
                        pix_next   = base_reg;
                        last_next  = 1'b0;
                        state_next = ST_RIGHT;
                    end
                    else
                    begin
                        pix_next  = PIX_W'(base_reg + 3'd4);
                        last_next = final_row;
                        base_next = PIX_W'(base_reg + cfg.stride);
                        if (final_row)
                        begin
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            mem_re     = 1'b1;
                            grow_next  = GROW_W'(grow_reg + 1'b1);
                            state_next = ST_LEFT;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign result_valid = out_valid_reg;
    assign kind         = kind_reg;
    assign pixel_index  = pix_reg;
    assign color0       = c0_reg;
    assign color1       = c1_reg;
    assign color2       = c2_reg;
    assign color3       = c3_reg;
    assign last         = last_reg;

endmodule

// ===== src/text_console_glyph_renderer.sv =====
`timescale 1ns / 1ps
// Text console glyph renderer. Requests arrive on the item channel: a font
// load writes one byte of the 8x16 font store, a character byte moves the
// cursor and, for a printable code, is turned into framebuffer commands.
// Results leave on the result channel: an optional scroll-up command first,
// then 32 writes of four pixels each, with last set on the final one. A
// newline on the last row gives one scroll command alone, with last set.
// Colours and screen geometry are set through the APB port while idle, a
// user's rule the block does not enforce. A request is taken into a
// two-entry command queue in the cycle it is accepted and popped by the
// render sequencer when idle. The sequencer emits one result per cycle into
// a single output register while the receiver does not stall, and takes no
// new command until a character's last result is registered. Carriage return
// and a newline that does not scroll are handled by the front end alone.
// Reset puts the cursor at the top left, loads the default registers and
// empties the queue; the font store is not cleared and must be loaded first.
// When the receiver stalls the output register holds its result, the
// sequencer waits, and requests are taken until the queue is full.
module text_console_glyph_renderer (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [4:0]                   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    input  logic                         item_valid,
    output logic                         item_ready,
    input  logic                         req_type,
    input  logic [tcgr_pkg::CODE_W-1:0]  char_code,
    input  logic [tcgr_pkg::FONT_AW-1:0] font_index,
    input  logic [7:0]                   font_bits,
    output logic                         result_valid,
    input  logic                         result_ready,
    output logic                         kind,
    output logic [tcgr_pkg::PIX_W-1:0]   pixel_index,
    output logic [tcgr_pkg::COLOR_W-1:0] color0,
    output logic [tcgr_pkg::COLOR_W-1:0] color1,
    output logic [tcgr_pkg::COLOR_W-1:0] color2,
    output logic [tcgr_pkg::COLOR_W-1:0] color3,
    output logic                         last
);
    import tcgr_pkg::*;

    logic [COLOR_W-1:0]    fg_reg, bg_reg;
    logic [CFG_COLS_W-1:0] cols_reg;
    logic [CFG_ROWS_W-1:0] rows_reg;
    logic [STRIDE_W-1:0]   stride_reg;
    logic                  wr_en;
    reg_index_t            reg_sel;
    cfg_t                  cfg;

    logic                  push, pop, queue_full, queue_empty;
    cmd_t                  push_cmd, head;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_sel = reg_index_t'(paddr[4:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fg_reg     <= 32'h00FF_FFFF;
            bg_reg     <= '0;
            cols_reg   <= CFG_COLS_W'(180);
            rows_reg   <= CFG_ROWS_W'(56);
            stride_reg <= STRIDE_W'(1440);
        end
        else if (wr_en)
        begin
            case (reg_sel)
                REG_FG:     fg_reg     <= pwdata;
                REG_BG:     bg_reg     <= pwdata;
                REG_COLS:   cols_reg   <= pwdata[CFG_COLS_W-1:0];
                REG_ROWS:   rows_reg   <= pwdata[CFG_ROWS_W-1:0];
                REG_STRIDE: stride_reg <= pwdata[STRIDE_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_FG:     prdata = fg_reg;
            REG_BG:     prdata = bg_reg;
            REG_COLS:   prdata = 32'(cols_reg);
            REG_ROWS:   prdata = 32'(rows_reg);
            REG_STRIDE: prdata = 32'(stride_reg);
            default:    prdata = '0;
        endcase
    end

    // Geometry registers are saturated into their usable ranges here.
    always_comb
    begin
        cfg.fg = fg_reg;
        cfg.bg = bg_reg;
        if (cols_reg == '0)
        begin
            cfg.cols = COL_W'(1);
        end
        else if (32'(cols_reg) > MAX_TEXT_COLS)
        begin
            cfg.cols = COL_W'(MAX_TEXT_COLS);
        end
        else
        begin
            cfg.cols = COL_W'(cols_reg);
        end
        if (rows_reg == '0)
        begin
            cfg.rows = (ROW_W + 1)'(1);
        end
        else if (32'(rows_reg) > MAX_TEXT_ROWS)
        begin
            cfg.rows = (ROW_W + 1)'(MAX_TEXT_ROWS);
        end
        else
        begin
            cfg.rows = (ROW_W + 1)'(rows_reg);
        end
        if (32'(stride_reg) < MIN_LINE_STRIDE)
        begin
            cfg.stride = STRIDE_W'(MIN_LINE_STRIDE);
        end
        else if (32'(stride_reg) > MAX_LINE_STRIDE)
        begin
            cfg.stride = STRIDE_W'(MAX_LINE_STRIDE);
        end
        else
        begin
            cfg.stride = stride_reg;
        end
    end

    tcgr_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .req_type   (req_type),
        .char_code  (char_code),
        .font_index (font_index),
        .font_bits  (font_bits),
        .queue_full (queue_full),
        .push       (push),
        .push_cmd   (push_cmd)
    );

    tcgr_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (queue_full),
        .pop      (pop),
        .head     (head),
        .empty    (queue_empty)
    );

    tcgr_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .head         (head),
        .empty        (queue_empty),
        .pop          (pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .kind         (kind),
        .pixel_index  (pixel_index),
        .color0       (color0),
        .color1       (color1),
        .color2       (color2),
        .color3       (color3),
        .last         (last)
    );

endmodule

// ===== src/tcgr_checker.sv =====
`timescale 1ns / 1ps
module tcgr_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         pready,
    input logic                         result_valid,
    input logic                         result_ready,
    input logic                         kind,
    input logic [tcgr_pkg::PIX_W-1:0]   pixel_index,
    input logic [tcgr_pkg::COLOR_W-1:0] color1,
    input logic [tcgr_pkg::COLOR_W-1:0] color2,
    input logic [tcgr_pkg::COLOR_W-1:0] color3,
    input logic                         last
);
    import tcgr_pkg::*;

    a_reset_quiet: assert property (@(posedge clk) !rst_n |-> !result_valid)
        else $error("result offered during reset");

    a_scroll_form: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && kind == KIND_SCROLL) |->
            (pixel_index == '0 && color1 == '0 && color2 == '0 && color3 == '0))
        else $error("scroll command carries pixel data");

    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_ready) |=> result_valid)
        else $error("result withdrawn before it was taken");

    a_payload_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_ready) |=>
            ($stable(kind) && $stable(pixel_index) && $stable(last)))
        else $error("stalled result changed");

    a_pready_high: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("configuration port inserted a wait state");

endmodule

bind text_console_glyph_renderer tcgr_checker u_tcgr_checker (.*);

// ===== dv/text_console_glyph_renderer_tb.sv =====
`timescale 1ns / 1ps
module text_console_glyph_renderer_tb;

    import tcgr_pkg::*;

    typedef struct packed {
        logic                       rt;
        logic [CODE_W-1:0]          code;
        logic [FONT_AW-1:0]         fidx;
        logic [7:0]                 fbits;
    } console_req_t;

    typedef struct packed {
        logic                       kind;
        logic [PIX_W-1:0]           pix;
        logic [3:0][COLOR_W-1:0]    color;
        logic                       last;
    } fb_cmd_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [4:0]             paddr = '0;
    logic [31:0]            pwdata = '0;
    logic [31:0]            prdata;
    logic                   pready;
    logic                   item_valid = 1'b0;
    logic                   item_ready;
    logic                   req_type = REQ_CHAR;
    logic [CODE_W-1:0]      char_code = '0;
    logic [FONT_AW-1:0]     font_index = '0;
    logic [7:0]             font_bits = '0;
    logic                   result_valid;
    logic                   result_ready = 1'b0;
    logic                   kind;
    logic [PIX_W-1:0]       pixel_index;
    logic [COLOR_W-1:0]     color0;
    logic [COLOR_W-1:0]     color1;
    logic [COLOR_W-1:0]     color2;
    logic [COLOR_W-1:0]     color3;
    logic                   last;

    text_console_glyph_renderer dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .req_type     (req_type),
        .char_code    (char_code),
        .font_index   (font_index),
        .font_bits    (font_bits),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .kind         (kind),
        .pixel_index  (pixel_index),
        .color0       (color0),
        .color1       (color1),
        .color2       (color2),
        .color3       (color3),
        .last         (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Predicted console state, updated as each request is accepted.
    cfg_t               console_cfg;
    logic [COL_W-1:0]   cursor_col;
    logic [ROW_W-1:0]   cursor_row;
    logic [7:0]         font_img [FONT_DEPTH];

    console_req_t       pending_reqs [$];
    fb_cmd_t            expected_cmds [$];
    int                 error_count = 0;
    int                 items_queued = 0;

    // Generator-side view of which font bytes have been loaded.
    bit                 byte_loaded [FONT_DEPTH];
    bit                 glyph_ready [256];
    logic [CODE_W-1:0]  usable_codes [$];

    int                 burst_left = 0;
    int                 gap_left = 0;
    console_req_t       head_req;

    logic               hold_request = 1'b0;
    bit                 hold_done = 1'b0;
    int                 hold_left = 0;
    int                 mode_left = 0;
    int                 stall_mode = 0;
    logic [31:0]        stall_word = '0;
    logic               ready_next;

    fb_cmd_t            want_cmd;

    task automatic push_scroll(input logic is_last);
        fb_cmd_t cmd;
        cmd.kind = KIND_SCROLL;
        cmd.pix = '0;
        cmd.color = '0;
        cmd.color[0] = console_cfg.bg;
        cmd.last = is_last;
        expected_cmds.push_back(cmd);
    endtask

    task automatic model_request(input logic rt, input logic [CODE_W-1:0] code,
                                 input logic [FONT_AW-1:0] fidx, input logic [7:0] fbits);
        int unsigned cols;
        int unsigned rows;
        int unsigned stride;
        int unsigned base;
        logic [7:0]  bits;
        fb_cmd_t     cmd;
        cols = (console_cfg.cols == 0) ? 1 :
               (console_cfg.cols > MAX_TEXT_COLS) ? MAX_TEXT_COLS : console_cfg.cols;
        rows = (console_cfg.rows == 0) ? 1 :
               (console_cfg.rows > MAX_TEXT_ROWS) ? MAX_TEXT_ROWS : console_cfg.rows;
        stride = (console_cfg.stride < MIN_LINE_STRIDE) ? MIN_LINE_STRIDE :
                 (console_cfg.stride > MAX_LINE_STRIDE) ? MAX_LINE_STRIDE : console_cfg.stride;
        if (rt == REQ_FONT)
        begin
            font_img[fidx] = fbits;
            return;
        end
        if (cursor_row >= rows)
            cursor_row = ROW_W'(rows - 1);
        if (code == CHAR_NL)
        begin
            cursor_col = '0;
            if (cursor_row >= rows - 1)
                push_scroll(1'b1);
            else
                cursor_row = cursor_row + 1'b1;
            return;
        end
        if (code == CHAR_CR)
        begin
            cursor_col = '0;
            return;
        end
        if (cursor_col >= cols)
        begin
            cursor_col = '0;
            if (int'(cursor_row) + 1 >= rows)
            begin
                push_scroll(1'b0);
                cursor_row = ROW_W'(rows - 1);
            end
            else
                cursor_row = cursor_row + 1'b1;
        end
        for (int r = 0; r < GLYPH_ROWS; r++)
        begin
            bits = font_img[(int'(code) * GLYPH_ROWS + r) % FONT_DEPTH];
            base = stride * (int'(cursor_row) * GLYPH_ROWS + r) + int'(cursor_col) * 8;
            for (int h = 0; h < 2; h++)
            begin
                cmd.kind = KIND_PIXELS;
                cmd.pix = PIX_W'(base + h * 4);
                for (int b = 0; b < 4; b++)
                    cmd.color[b] = bits[7 - (h * 4 + b)] ? console_cfg.fg : console_cfg.bg;
                cmd.last = (r == GLYPH_ROWS - 1) && (h == 1);
                expected_cmds.push_back(cmd);
            end
        end
        cursor_col = cursor_col + 1'b1;
    endtask

    task automatic push_req(input logic rt, input logic [CODE_W-1:0] code,
                            input logic [FONT_AW-1:0] fidx, input logic [7:0] fbits);
        console_req_t req;
        int           g;
        bit           complete;
        req.rt = rt;
        req.code = code;
        req.fidx = fidx;
        req.fbits = fbits;
        pending_reqs.push_back(req);
        items_queued++;
        if (rt == REQ_FONT)
        begin
            byte_loaded[fidx] = 1'b1;
            g = int'(fidx) / GLYPH_ROWS;
            if (!glyph_ready[g])
            begin
                complete = 1'b1;
                for (int r = 0; r < GLYPH_ROWS; r++)
                    if (!byte_loaded[g * GLYPH_ROWS + r])
                        complete = 1'b0;
                if (complete)
                begin
                    glyph_ready[g] = 1'b1;
                    usable_codes.push_back(CODE_W'(g));
                end
            end
        end
    endtask

    task automatic put_char(input logic [CODE_W-1:0] code);
        push_req(REQ_CHAR, code, FONT_AW'($urandom), 8'($urandom));
    endtask

    task automatic put_load(input logic [FONT_AW-1:0] fidx, input logic [7:0] fbits);
        push_req(REQ_FONT, CODE_W'($urandom), fidx, fbits);
    endtask

    task automatic reg_write(input reg_index_t idx, input logic [31:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 5'(4 * int'(idx));
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_FG:     console_cfg.fg = value;
            REG_BG:     console_cfg.bg = value;
            REG_COLS:   console_cfg.cols = value[CFG_COLS_W-1:0];
            REG_ROWS:   console_cfg.rows = value[CFG_ROWS_W-1:0];
            REG_STRIDE: console_cfg.stride = value[STRIDE_W-1:0];
            default:    ;
        endcase
    endtask

    task automatic wait_idle();
        while (pending_reqs.size() != 0 || item_valid || expected_cmds.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            error_count++;
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
            item_valid <= 1'b0;
        else
        begin
            if (item_valid && item_ready)
                model_request(req_type, char_code, font_index, font_bits);
            if (!item_valid || item_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    item_valid <= 1'b0;
                end
                else if (pending_reqs.size() == 0)
                    item_valid <= 1'b0;
                else
                begin
                    head_req = pending_reqs.pop_front();
                    req_type <= head_req.rt;
                    char_code <= head_req.code;
                    font_index <= head_req.fidx;
                    font_bits <= head_req.fbits;
                    item_valid <= 1'b1;
                    if (burst_left > 1)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(1, 16);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                    end
                end
            end
        end
    end

    // The receiver changes its stall behaviour periodically at random, and once
    // holds off so that the request queue fills up.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            result_ready <= 1'b0;
            mode_left = 0;
        end
        else
        begin
            if (hold_request && !hold_done)
            begin
                hold_left = 600;
                hold_done = 1'b1;
            end
            if (mode_left == 0)
            begin
                mode_left = 48;
                stall_mode = $urandom_range(0, 3);
                stall_word = $urandom;
            end
            mode_left--;
            case (stall_mode)
                0:       ready_next = 1'b1;
                1:       ready_next = 1'($urandom_range(0, 1));
                2:       ready_next = stall_word[mode_left % 32];
                default: ready_next = ($urandom_range(0, 3) == 0);
            endcase
            if (hold_left > 0)
            begin
                hold_left--;
                ready_next = 1'b0;
            end
            result_ready <= ready_next;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
        begin
            if (expected_cmds.size() == 0)
            begin
                $display("%0t: unexpected result, expected nothing, got kind %0h pixel_index %0h",
                         $time, kind, pixel_index);
                error_count++;
            end
            else
            begin
                want_cmd = expected_cmds.pop_front();
                check_field("kind", 32'(want_cmd.kind), 32'(kind));
                check_field("pixel_index", 32'(want_cmd.pix), 32'(pixel_index));
                check_field("color0", want_cmd.color[0], color0);
                check_field("color1", want_cmd.color[1], color1);
                check_field("color2", want_cmd.color[2], color2);
                check_field("color3", want_cmd.color[3], color3);
                check_field("last", 32'(want_cmd.last), 32'(last));
            end
        end
    end

    initial
    begin
        int sel;
        int g;
        rst_n <= 1'b0;
        console_cfg.fg = 32'h00FF_FFFF;
        console_cfg.bg = '0;
        console_cfg.cols = 180;
        console_cfg.rows = 56;
        console_cfg.stride = 1440;
        cursor_col = '0;
        cursor_row = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Two glyphs with edge patterns: single bits, all but one bit, full and empty rows.
        for (int r = 0; r < GLYPH_ROWS; r++)
            put_load(FONT_AW'(r), (r < 8) ? (8'h80 >> r) : ~(8'h80 >> (r - 8)));
        for (int r = 0; r < GLYPH_ROWS; r++)
            put_load(FONT_AW'(8'hFF * GLYPH_ROWS + r), r[0] ? 8'h00 : 8'hFF);
        put_char(8'h00);
        put_char(8'hFF);
        put_char(CHAR_CR);
        put_char(CHAR_NL);
        put_char(8'h00);
        wait_idle();

        // A tiny screen: wrapping, scrolling before a glyph, newline on the last row.
        reg_write(REG_FG, 32'hFFFF_FFFF);
        reg_write(REG_BG, 32'h0000_0000);
        reg_write(REG_COLS, 2);
        reg_write(REG_ROWS, 2);
        reg_write(REG_STRIDE, 16);
        repeat (4) put_char(8'hFF);
        put_char(CHAR_NL);
        put_char(CHAR_CR);
        put_char(8'h00);
        wait_idle();

        // Shrinking the screen leaves the cursor below it.
        reg_write(REG_COLS, 1);
        reg_write(REG_ROWS, 1);
        reg_write(REG_STRIDE, 8);
        put_char(8'h00);
        put_char(8'hFF);
        put_char(CHAR_NL);
        wait_idle();

        // Register values below their ranges.
        reg_write(REG_FG, 32'h0000_0000);
        reg_write(REG_BG, 32'hFFFF_FFFF);
        reg_write(REG_COLS, 0);
        reg_write(REG_ROWS, 0);
        reg_write(REG_STRIDE, 0);
        put_char(8'hFF);
        put_char(8'h00);
        put_char(CHAR_NL);
        wait_idle();

        // Largest screen, cursor walked down to the bottom row.
        reg_write(REG_FG, $urandom);
        reg_write(REG_BG, $urandom);
        reg_write(REG_COLS, MAX_TEXT_COLS);
        reg_write(REG_ROWS, MAX_TEXT_ROWS);
        reg_write(REG_STRIDE, MAX_LINE_STRIDE);
        repeat (MAX_TEXT_ROWS + 1) put_char(CHAR_NL);
        put_char(8'hFF);
        put_char(8'h00);
        wait_idle();

        // Register values above their ranges.
        reg_write(REG_COLS, 511);
        reg_write(REG_ROWS, 127);
        reg_write(REG_STRIDE, 8191);
        put_char(8'h00);
        put_char(CHAR_NL);
        put_char(8'hFF);
        wait_idle();

        while (items_queued < 430)
        begin
            reg_write(REG_FG, $urandom);
            reg_write(REG_BG, $urandom);
            reg_write(REG_COLS, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 511)
                                                            : $urandom_range(1, 12));
            reg_write(REG_ROWS, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127)
                                                            : $urandom_range(1, 6));
            reg_write(REG_STRIDE, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8191)
                                                              : $urandom_range(8, 4096));
            hold_request <= 1'b1;
            for (int k = 0; k < 40; k++)
            begin
                sel = $urandom_range(0, 99);
                if (sel < 3)
                begin
                    g = $urandom_range(0, 255);
                    for (int r = 0; r < GLYPH_ROWS; r++)
                        put_load(FONT_AW'(g * GLYPH_ROWS + r), 8'($urandom));
                end
                else if (sel < 8)
                    put_load(FONT_AW'($urandom), 8'($urandom));
                else if (sel < 20)
                    put_char(CHAR_NL);
                else if (sel < 26)
                    put_char(CHAR_CR);
                else
                    put_char(usable_codes[$urandom_range(0, usable_codes.size() - 1)]);
            end
            wait_idle();
        end

        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #3000000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
